FILE: design/scd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the semigraphic cell draw block
package scd_pkg;

  localparam int unsigned OFF_W      = 12;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned XPOS_W     = 16;
  localparam int unsigned YPOS_W     = 20;
  localparam int unsigned DIM_W      = 8;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned DIV_STAGES = OFF_W;
  localparam int unsigned Q_DEPTH    = 16;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W      = Q_PTR_W + 1;
  localparam int unsigned SLOTS      = 7;
  localparam int unsigned SLOT_W     = 3;

  // divide by three as multiply by 171 and shift by 9, exact for 8-bit values
  localparam int unsigned THIRD_MUL   = 171;
  localparam int unsigned THIRD_SHIFT = 9;
  localparam int unsigned THIRD_W     = 16;

  localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;
  localparam int unsigned BIT_GRAPHIC = 7;
  localparam int unsigned BIT_LOWER   = 6;
  localparam int unsigned BIT_UPPER   = 5;

  localparam logic [DIM_W-1:0]   RST_COLUMNS   = 8'd64;
  localparam logic [DIM_W-1:0]   RST_CELL_W    = 8'd8;
  localparam logic [DIM_W-1:0]   RST_CELL_H    = 8'd12;
  localparam logic               RST_LOWERCASE = 1'b1;
  localparam logic [COLOR_W-1:0] RST_FORE      = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] RST_BACK      = 32'h0000_00FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS     = 3'd0,
    REG_CELL_WIDTH  = 3'd1,
    REG_CELL_HEIGHT = 3'd2,
    REG_LOWERCASE   = 3'd3,
    REG_FG_RGBA     = 3'd4,
    REG_BG_RGBA     = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    KIND_RECT  = 1'b0,
    KIND_GLYPH = 1'b1
  } kind_e;

  // command slots in emission order
  typedef enum logic [SLOT_W-1:0] {
    SLOT_BACK = 3'd0,
    SLOT_TL   = 3'd1,
    SLOT_ML   = 3'd2,
    SLOT_BL   = 3'd3,
    SLOT_BR   = 3'd4,
    SLOT_MR   = 3'd5,
    SLOT_TR   = 3'd6
  } slot_e;

  typedef struct packed {
    logic [DIM_W-1:0]   columns;
    logic [DIM_W-1:0]   cell_width;
    logic [DIM_W-1:0]   cell_height;
    logic               lowercase_mod;
    logic [COLOR_W-1:0] fg_rgba;
    logic [COLOR_W-1:0] bg_rgba;
    logic [DIM_W-1:0]   w_left;
    logic [DIM_W-1:0]   w_right;
    logic [DIM_W-1:0]   h_third;
    logic [DIM_W-1:0]   h_bottom;
  } cfg_t;

  typedef struct packed {
    logic [XPOS_W-1:0] x;
    logic [XPOS_W-1:0] xr;
    logic [YPOS_W-1:0] y;
    logic [YPOS_W-1:0] ym;
    logic [YPOS_W-1:0] yb;
    logic [CODE_W-1:0] glyph;
    logic              is_glyph;
    logic [SLOTS-1:0]  mask;
  } entry_t;

endpackage

FILE: design/scd_if.sv
`timescale 1ns / 1ps
// channel interfaces: cell input, draw command output, register writes
interface scd_cell_if;
  import scd_pkg::*;
  logic              valid;
  logic              ready;
  logic [OFF_W-1:0]  cell_offset;
  logic [CODE_W-1:0] char_code;
  modport source (output valid, cell_offset, char_code, input ready);
  modport sink (input valid, cell_offset, char_code, output ready);
endinterface

interface scd_cmd_if;
  import scd_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [COLOR_W-1:0] color;
  logic [XPOS_W-1:0]  x_pos;
  logic [YPOS_W-1:0]  y_pos;
  logic [DIM_W-1:0]   rect_width;
  logic [DIM_W-1:0]   rect_height;
  logic [CODE_W-1:0]  glyph;
  logic               last;
  modport source (output valid, kind, color, x_pos, y_pos, rect_width, rect_height,
                  glyph, last, input ready);
  modport sink (input valid, kind, color, x_pos, y_pos, rect_width, rect_height,
                glyph, last, output ready);
endinterface

interface scd_cfg_if;
  import scd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/scd_front.sv
`timescale 1ns / 1ps
// front end: pipelined offset divide, position multiply, code classification
module scd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  scd_pkg::cfg_t               cfg_i,
  input  logic                        valid_i,
  input  logic [scd_pkg::OFF_W-1:0]   offset_i,
  input  logic [scd_pkg::CODE_W-1:0]  code_i,
  output logic                        ent_valid_o,
  output scd_pkg::entry_t             ent_o
);
  import scd_pkg::*;

  logic [DIV_STAGES:0] vld_q;
  logic [DIM_W-1:0]    rem_q  [DIV_STAGES+1];
  logic [OFF_W-1:0]    num_q  [DIV_STAGES+1];
  logic [CODE_W-1:0]   code_q [DIV_STAGES+1];

  logic [DIM_W:0]      trial  [1:DIV_STAGES];
  logic [DIM_W:0]      diff   [1:DIV_STAGES];
  logic                ge     [1:DIV_STAGES];
  logic [DIM_W-1:0]    rem_d  [1:DIV_STAGES];
  logic [OFF_W-1:0]    num_d  [1:DIV_STAGES];

  logic                mul_vld_q;
  logic [XPOS_W-1:0]   x_q;
  logic [YPOS_W-1:0]   y_q;
  logic [CODE_W-1:0]   mcode_q;

  logic                ent_vld_q;
  entry_t              ent_q, ent_d;

  logic                graphic;
  logic [CODE_W-1:0]   adj;

  // one quotient bit per stage, restoring division
  always_comb begin
    for (int s = 1; s <= DIV_STAGES; s++) begin
      trial[s] = {rem_q[s-1], num_q[s-1][OFF_W-1]};
      diff[s]  = trial[s] - {1'b0, cfg_i.columns};
      ge[s]    = trial[s] >= {1'b0, cfg_i.columns};
      rem_d[s] = ge[s] ? diff[s][DIM_W-1:0] : trial[s][DIM_W-1:0];
      num_d[s] = {num_q[s-1][OFF_W-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      mul_vld_q <= 1'b0;
      ent_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[DIV_STAGES-1:0], valid_i};
      mul_vld_q <= vld_q[DIV_STAGES];
      ent_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    num_q[0]  <= offset_i;
    code_q[0] <= code_i;
    for (int s = 1; s <= DIV_STAGES; s++) begin
      rem_q[s]  <= rem_d[s];
      num_q[s]  <= num_d[s];
      code_q[s] <= code_q[s-1];
    end
    x_q     <= XPOS_W'(rem_q[DIV_STAGES]) * XPOS_W'(cfg_i.cell_width);
    y_q     <= YPOS_W'(num_q[DIV_STAGES]) * YPOS_W'(cfg_i.cell_height);
    mcode_q <= code_q[DIV_STAGES];
    ent_q   <= ent_d;
  end

  always_comb begin
    graphic = mcode_q[BIT_GRAPHIC] || (mcode_q == CODE_SPACE);
    adj     = mcode_q;
    if (!cfg_i.lowercase_mod) begin
      adj[BIT_LOWER] = ~mcode_q[BIT_UPPER];
    end

    ent_d.x     = x_q;
    ent_d.xr    = x_q + XPOS_W'(cfg_i.w_left);
    ent_d.y     = y_q;
    ent_d.ym    = y_q + YPOS_W'(cfg_i.h_third);
    ent_d.yb    = ent_d.ym + YPOS_W'(cfg_i.h_third);
    ent_d.glyph = graphic ? '0 : adj;
    ent_d.is_glyph = !graphic;
    ent_d.mask  = '0;
    ent_d.mask[SLOT_BACK] = 1'b1;
    if (!graphic) begin
      ent_d.mask[SLOT_TL] = (adj != CODE_SPACE);
    end else if (mcode_q != CODE_SPACE) begin
      ent_d.mask[SLOT_TL] = mcode_q[0];
      ent_d.mask[SLOT_ML] = mcode_q[2];
      ent_d.mask[SLOT_BL] = mcode_q[4];
      ent_d.mask[SLOT_BR] = mcode_q[5];
      ent_d.mask[SLOT_MR] = mcode_q[3];
      ent_d.mask[SLOT_TR] = mcode_q[1];
    end
  end

  assign ent_valid_o = ent_vld_q;
  assign ent_o       = ent_q;

endmodule

FILE: design/scd_queue.sv
`timescale 1ns / 1ps
// queue of classified cells between front and back
module scd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  scd_pkg::entry_t wr_data_i,
  input  logic            pop_i,
  output logic            rd_valid_o,
  output scd_pkg::entry_t rd_data_o
);
  import scd_pkg::*;

  entry_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(wr_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];

endmodule

FILE: design/scd_back.sv
`timescale 1ns / 1ps
// back end: steps through the pending commands of the head cell
module scd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scd_pkg::cfg_t   cfg_i,
  input  logic            head_valid_i,
  input  scd_pkg::entry_t head_i,
  output logic            pop_o,
  scd_cmd_if.source       cmd_o
);
  import scd_pkg::*;

  logic [SLOTS-1:0]   done_q, done_d;
  logic [SLOTS-1:0]   remain, sel_oh, rest;
  slot_e              slot;
  logic               load, is_last;

  logic               out_valid_q;
  logic               kind_q, kind_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic [XPOS_W-1:0]  x_q, x_d;
  logic [YPOS_W-1:0]  y_q, y_d;
  logic [DIM_W-1:0]   w_q, w_d;
  logic [DIM_W-1:0]   h_q, h_d;
  logic [CODE_W-1:0]  glyph_q, glyph_d;
  logic               last_q;

  always_comb begin
    remain  = head_i.mask & ~done_q;
    sel_oh  = remain & (~remain + 1'b1);
    rest    = remain & ~sel_oh;
    is_last = (rest == '0);
    slot    = SLOT_BACK;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (remain[i]) begin
        slot = slot_e'(SLOT_W'(i));
      end
    end
    load   = head_valid_i && (!out_valid_q || cmd_o.ready);
    pop_o  = load && is_last;
    done_d = is_last ? '0 : (done_q | sel_oh);
  end

  // command fields for the selected slot
  always_comb begin
    kind_d  = KIND_RECT;
    color_d = cfg_i.fg_rgba;
    x_d     = head_i.x;
    y_d     = head_i.y;
    w_d     = cfg_i.w_left;
    h_d     = cfg_i.h_third;
    glyph_d = '0;
    unique case (slot)
      SLOT_BACK: begin
        color_d = cfg_i.bg_rgba;
        w_d     = cfg_i.cell_width;
        h_d     = cfg_i.cell_height;
      end
      SLOT_TL: begin
        if (head_i.is_glyph) begin
          kind_d  = KIND_GLYPH;
          w_d     = '0;
          h_d     = '0;
          glyph_d = head_i.glyph;
        end
      end
      SLOT_ML: begin
        y_d = head_i.ym;
      end
      SLOT_BL: begin
        y_d = head_i.yb;
        h_d = cfg_i.h_bottom;
      end
      SLOT_BR: begin
        x_d = head_i.xr;
        y_d = head_i.yb;
        w_d = cfg_i.w_right;
        h_d = cfg_i.h_bottom;
      end
      SLOT_MR: begin
        x_d = head_i.xr;
        y_d = head_i.ym;
        w_d = cfg_i.w_right;
      end
      SLOT_TR: begin
        x_d = head_i.xr;
        w_d = cfg_i.w_right;
      end
      default: begin
        kind_d = KIND_RECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        done_q      <= done_d;
      end else if (cmd_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_d;
      color_q <= color_d;
      x_q     <= x_d;
      y_q     <= y_d;
      w_q     <= w_d;
      h_q     <= h_d;
      glyph_q <= glyph_d;
      last_q  <= is_last;
    end
  end

  assign cmd_o.valid       = out_valid_q;
  assign cmd_o.kind        = kind_q;
  assign cmd_o.color       = color_q;
  assign cmd_o.x_pos       = x_q;
  assign cmd_o.y_pos       = y_q;
  assign cmd_o.rect_width  = w_q;
  assign cmd_o.rect_height = h_q;
  assign cmd_o.glyph       = glyph_q;
  assign cmd_o.last        = last_q;

endmodule

FILE: design/semigraphic_cell_draw_commands.sv
`timescale 1ns / 1ps
// Semigraphic cell draw-command generator, top level.
// cell_i takes one video-memory cell (offset, code) per item; cmd_o gives
// the draw commands for it, background rectangle first, last set on the
// final command of the cell. cfg_i writes the six registers by index
// (columns, cell width, cell height, lowercase mod, fore and back color),
// always ready; write only while no cell is in flight.
// An accepted cell passes the input register, the 12-stage offset divider,
// the position multiply, the classification register and the queue.
// Throughput: one command per cycle on cmd_o while it is not stalled; a
// cell yields 1 to 7 commands depending on its code. Cells enter back to
// back while a 16-entry queue and its credit count have room.
// Reset restores the register defaults and empties pipeline and queue.
// When cmd_o stalls the held command stays put, the queue fills, and
// cell_i.ready drops once 16 cells are waiting or in flight.
module semigraphic_cell_draw_commands (
  input  logic      clk_i,
  input  logic      rst_ni,
  scd_cell_if.sink  cell_i,
  scd_cfg_if.sink   cfg_i,
  scd_cmd_if.source cmd_o
);
  import scd_pkg::*;

  logic [DIM_W-1:0]   columns_q;
  logic [DIM_W-1:0]   cell_w_q;
  logic [DIM_W-1:0]   cell_h_q;
  logic               lower_q;
  logic [COLOR_W-1:0] fore_q;
  logic [COLOR_W-1:0] back_q;

  cfg_t               cfg;
  logic [THIRD_W-1:0] third_prod;

  logic               cell_acc, cfg_acc;
  logic [CNT_W-1:0]   credit_q, credit_d;

  logic               ent_valid;
  entry_t             ent;
  logic               head_valid;
  entry_t             head;
  logic               pop;

  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= RST_COLUMNS;
      cell_w_q  <= RST_CELL_W;
      cell_h_q  <= RST_CELL_H;
      lower_q   <= RST_LOWERCASE;
      fore_q    <= RST_FORE;
      back_q    <= RST_BACK;
    end else if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_COLUMNS:     columns_q <= cfg_i.data[DIM_W-1:0];
        REG_CELL_WIDTH:  cell_w_q  <= cfg_i.data[DIM_W-1:0];
        REG_CELL_HEIGHT: cell_h_q  <= cfg_i.data[DIM_W-1:0];
        REG_LOWERCASE:   lower_q   <= cfg_i.data[0];
        REG_FG_RGBA:     fore_q    <= cfg_i.data[COLOR_W-1:0];
        REG_BG_RGBA:     back_q    <= cfg_i.data[COLOR_W-1:0];
        default: begin
          lower_q <= lower_q;
        end
      endcase
    end
  end

  // derived sub-block geometry; columns of zero act as one
  always_comb begin
    third_prod        = THIRD_W'(cell_h_q) * THIRD_W'(THIRD_MUL);
    cfg.columns       = (columns_q == '0) ? DIM_W'(1) : columns_q;
    cfg.cell_width    = cell_w_q;
    cfg.cell_height   = cell_h_q;
    cfg.lowercase_mod = lower_q;
    cfg.fg_rgba       = fore_q;
    cfg.bg_rgba       = back_q;
    cfg.w_left        = cell_w_q >> 1;
    cfg.w_right       = cell_w_q - cfg.w_left;
    cfg.h_third       = DIM_W'(third_prod >> THIRD_SHIFT);
    cfg.h_bottom      = cell_h_q - cfg.h_third - cfg.h_third;
  end

  // credits cover every cell between the input and the queue head
  assign cell_acc     = cell_i.valid && cell_i.ready;
  assign cell_i.ready = (credit_q < CNT_W'(Q_DEPTH));
  assign credit_d     = credit_q + CNT_W'(cell_acc) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  scd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (cell_acc),
    .offset_i    (cell_i.cell_offset),
    .code_i      (cell_i.char_code),
    .ent_valid_o (ent_valid),
    .ent_o       (ent)
  );

  scd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (ent_valid),
    .wr_data_i  (ent),
    .pop_i      (pop),
    .rd_valid_o (head_valid),
    .rd_data_o  (head)
  );

  scd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .cmd_o        (cmd_o)
  );

endmodule
